// ===== src/set_assoc_cache_lru_lookup_macros.svh =====
// assertion macros for the set associative cache lookup block
// used by the top level only, expects clk and arst_n in scope
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define SACL_ASSERT_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("check failed");

// condition in this cycle implies consequence in the next cycle
`define SACL_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("check failed");

`endif

// ===== src/sacl_pkg.sv =====
// shared types and constants of the cache lookup block
// no dependencies
package sacl_pkg;

	localparam int AGE_W   = 32;
	localparam int STAMP_W = 64;
	localparam logic [AGE_W-1:0] AGE_TOP = '1;

	// configuration register indexes
	localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [1:0] CFG_SET_BITS    = 2'd1;
	localparam logic [1:0] CFG_WAYS        = 2'd2;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_INDEX,
		CMD_COMPARE,
		CMD_UPDATE,
		CMD_CLEAR,
		CMD_SWEEP_START,
		CMD_SWEEP,
		CMD_SWEEP_END
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
	} ctl_cmd_t;

	typedef struct packed {
		logic row_last;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== src/set_assoc_cache_lru_lookup.sv =====
// set associative cache tag store with lru replacement, one address per item
// the set row of a taken item is read, compared and written back in INDEX, COMPARE
// and UPDATE; the next item waits for the write back, which a stalled output holds
// reset: a clearing pass over all MAX_SETS rows runs before the first item is taken
// a write to the set or way count requests an age rebase pass over all rows
module set_assoc_cache_lru_lookup #(
	parameter int MAX_SETS  = 1024,
	parameter int MAX_WAYS  = 16,
	parameter int ADDR_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ADDR_BITS-1:0] address,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [4:0]           cfg_data
);
	import sacl_pkg::*;
	`include "set_assoc_cache_lru_lookup_macros.svh"

	ctl_cmd_t   cmd;
	dp_status_t st;

	// sequencer
	sacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.st        (st),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	// tag store and lookup logic
	sacl_datapath #(
		.MAX_SETS  (MAX_SETS),
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.address   (address),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.hit       (hit)
	);

	// a taken item keeps the input closed while it is looked up
	`SACL_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	// a new result only appears after a lookup in progress
	`SACL_ASSERT_NOW(a_result_from_lookup, $rose(out_valid), $past(in_stall))
	// no item is taken in a configuration cycle
	`SACL_ASSERT_NOW(a_cfg_blocks_input, cfg_we, in_stall)

endmodule

// ===== src/sacl_ctrl.sv =====
// sequencer of the cache lookup: clearing pass, age rebase pass, lookup steps
// depends on sacl_pkg
module sacl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  sacl_pkg::dp_status_t st,
	output sacl_pkg::ctl_cmd_t   cmd,
	output logic                 in_stall
);
	import sacl_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP0,
		ST_SWEEP,
		ST_SWEEP_END,
		ST_INDEX,
		ST_COMPARE,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   pending_q;
	logic   take;

	assign in_stall = !(state_q == ST_IDLE && !pending_q && !cfg_we);
	assign take     = in_valid && !in_stall;

	// command decode
	always_comb begin
		cmd.op = CMD_NONE;
		case (state_q)
			ST_CLEAR:     cmd.op = CMD_CLEAR;
			ST_IDLE: begin
				if (pending_q && !cfg_we)
					cmd.op = CMD_SWEEP_START;
				else if (take)
					cmd.op = CMD_ACCEPT;
			end
			ST_SWEEP0:    cmd.op = CMD_SWEEP;
			ST_SWEEP:     cmd.op = CMD_SWEEP;
			ST_SWEEP_END: cmd.op = CMD_SWEEP_END;
			ST_INDEX:     cmd.op = CMD_INDEX;
			ST_COMPARE:   cmd.op = CMD_COMPARE;
			ST_UPDATE:    cmd.op = st.out_busy ? CMD_NONE : CMD_UPDATE;
			default:      cmd.op = CMD_NONE;
		endcase
	end

	// state and rebase request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			pending_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == CFG_SET_BITS || cfg_index == CFG_WAYS))
				pending_q <= 1'b1;
			else if (state_q == ST_SWEEP_END)
				pending_q <= 1'b0;
			case (state_q)
				ST_CLEAR: if (st.row_last) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (pending_q && !cfg_we)
						state_q <= ST_SWEEP0;
					else if (take)
						state_q <= ST_INDEX;
				end
				ST_SWEEP0:    state_q <= st.row_last ? ST_SWEEP_END : ST_SWEEP;
				ST_SWEEP:     if (st.row_last) state_q <= ST_SWEEP_END;
				ST_SWEEP_END: state_q <= ST_IDLE;
				ST_INDEX:     state_q <= ST_COMPARE;
				ST_COMPARE:   state_q <= ST_UPDATE;
				ST_UPDATE:    if (!st.out_busy) state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/sacl_datapath.sv =====
// tag store memory, address split, age compare and victim choice
// depends on sacl_pkg, driven by sacl_ctrl commands
module sacl_datapath #(
	parameter int MAX_SETS  = 1024,
	parameter int MAX_WAYS  = 16,
	parameter int ADDR_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sacl_pkg::ctl_cmd_t   cmd,
	output sacl_pkg::dp_status_t st,
	input  logic [ADDR_BITS-1:0] address,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [4:0]           cfg_data,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic                 hit
);
	import sacl_pkg::*;

	localparam int ROW_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int TOP_SB = $clog2(MAX_SETS + 1) - 1;
	localparam int LVL    = $clog2(MAX_WAYS);
	localparam int P      = 1 << LVL;

	typedef struct packed {
		logic                 v;
		logic [ADDR_BITS-1:0] tag;
		logic [STAMP_W-1:0]   birth;
	} line_t;
	typedef line_t [MAX_WAYS-1:0] row_t;

	function automatic logic [AGE_W-1:0] sat_age(input logic [STAMP_W-1:0] d);
		logic [AGE_W-1:0] r;
		r = (d > STAMP_W'(AGE_TOP)) ? AGE_TOP : d[AGE_W-1:0];
		return r;
	endfunction

	row_t mem [MAX_SETS];
	row_t rdata_q;

	logic [4:0] off_q;
	logic [3:0] setb_q;
	logic [4:0] ways_q;
	logic [3:0] era_sb_q;
	logic [4:0] era_ways_q;
	logic [STAMP_W-1:0] cnt_q;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] wrow_q;
	logic sw_ok_q;
	logic out_valid_q;
	logic hit_q;

	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS-1:0] tag_q;
	logic [ROW_W-1:0]     set_q;
	logic [AGE_W-1:0]     age_q [MAX_WAYS];
	logic [MAX_WAYS-1:0]  hitv_q;
	logic [MAX_WAYS-1:0]  inv_q;

	logic [3:0] eff_sb;
	logic [4:0] eff_ways;

	// effective geometry from the live registers
	always_comb begin
		eff_sb = (int'(setb_q) > TOP_SB) ? 4'(TOP_SB) : setb_q;
		if (ways_q == 5'd0)
			eff_ways = 5'd1;
		else if (int'(ways_q) > MAX_WAYS)
			eff_ways = 5'(MAX_WAYS);
		else
			eff_ways = ways_q;
	end

	// address split into set and tag
	logic [ADDR_BITS-1:0] shifted, set_mask, set_full, tag_c;
	logic [5:0]           tag_sh;
	logic [ROW_W-1:0]     set_c;
	always_comb begin
		shifted  = addr_q >> off_q;
		set_mask = (ADDR_BITS'(1) << era_sb_q) - ADDR_BITS'(1);
		set_full = shifted & set_mask;
		set_c    = ROW_W'(set_full);
		tag_sh   = {1'b0, off_q} + {2'b00, era_sb_q};
		tag_c    = addr_q >> tag_sh;
	end

	// rebase of one row: freeze ages relative to a restarted counter
	row_t sweep_row;
	logic row_in;
	always_comb begin
		logic [AGE_W-1:0] a;
		row_in    = (32'(wrow_q) < (32'd1 << era_sb_q));
		sweep_row = rdata_q;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (row_in && w < int'(era_ways_q))
				a = sat_age(cnt_q - rdata_q[w].birth);
			else
				a = sat_age(STAMP_W'(0) - rdata_q[w].birth);
			sweep_row[w].birth = STAMP_W'(0) - STAMP_W'(a);
		end
	end

	// victim choice: lowest hit, else lowest invalid, else oldest
	logic             t_ok  [2*P];
	logic [AGE_W-1:0] t_age [2*P];
	logic [WAY_W-1:0] t_idx [2*P];
	logic [WAY_W-1:0] hit_way, inv_way, vic;
	logic             any_hit, any_inv;
	row_t             upd_row;
	always_comb begin
		any_hit = |hitv_q;
		any_inv = |inv_q;
		hit_way = '0;
		inv_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (hitv_q[w]) hit_way = WAY_W'(w);
			if (inv_q[w])  inv_way = WAY_W'(w);
		end
		for (int i = 0; i < 2 * P; i++) begin
			t_ok[i]  = 1'b0;
			t_age[i] = '0;
			t_idx[i] = '0;
		end
		for (int w = 0; w < P; w++) begin
			if (w < MAX_WAYS) begin
				t_ok[P + w]  = (w < int'(era_ways_q));
				t_age[P + w] = age_q[w];
			end
			t_idx[P + w] = WAY_W'(w);
		end
		for (int i = P - 1; i >= 1; i--) begin
			if (t_ok[2*i+1] && (!t_ok[2*i] || t_age[2*i+1] > t_age[2*i])) begin
				t_ok[i]  = 1'b1;
				t_age[i] = t_age[2*i+1];
				t_idx[i] = t_idx[2*i+1];
			end else begin
				t_ok[i]  = t_ok[2*i];
				t_age[i] = t_age[2*i];
				t_idx[i] = t_idx[2*i];
			end
		end
		vic = any_hit ? hit_way : (any_inv ? inv_way : t_idx[1]);
		upd_row = rdata_q;
		upd_row[vic].v     = 1'b1;
		upd_row[vic].tag   = tag_q;
		upd_row[vic].birth = cnt_q;
	end

	// memory port control
	logic             rd_en, wr_en;
	logic [ROW_W-1:0] rd_row, wr_row;
	row_t             wr_data;
	always_comb begin
		rd_en   = (cmd.op == CMD_INDEX) || (cmd.op == CMD_SWEEP);
		rd_row  = (cmd.op == CMD_INDEX) ? set_c : row_q;
		wr_en   = 1'b0;
		wr_row  = row_q;
		wr_data = '0;
		case (cmd.op)
			CMD_CLEAR: wr_en = 1'b1;
			CMD_SWEEP, CMD_SWEEP_END: begin
				wr_en   = sw_ok_q;
				wr_row  = wrow_q;
				wr_data = sweep_row;
			end
			CMD_UPDATE: begin
				wr_en   = 1'b1;
				wr_row  = set_q;
				wr_data = upd_row;
			end
			default: wr_en = 1'b0;
		endcase
	end

	// set memory, registered read
	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem[rd_row];
		if (wr_en)
			mem[wr_row] <= wr_data;
	end

	// payload registers of the lookup steps
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_ACCEPT)
			addr_q <= address;
		if (cmd.op == CMD_INDEX) begin
			set_q <= set_c;
			tag_q <= tag_c;
		end
		if (cmd.op == CMD_SWEEP)
			wrow_q <= row_q;
		if (cmd.op == CMD_COMPARE) begin
			for (int w = 0; w < MAX_WAYS; w++) begin
				age_q[w]  <= sat_age(cnt_q - rdata_q[w].birth);
				hitv_q[w] <= (w < int'(era_ways_q)) && rdata_q[w].v &&
				             (rdata_q[w].tag == tag_q);
				inv_q[w]  <= (w < int'(era_ways_q)) && !rdata_q[w].v;
			end
		end
		if (cmd.op == CMD_UPDATE)
			hit_q <= any_hit;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= 5'd4;
			setb_q      <= 4'd0;
			ways_q      <= 5'd1;
			era_sb_q    <= 4'd0;
			era_ways_q  <= 5'd1;
			cnt_q       <= '0;
			row_q       <= '0;
			sw_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OFFSET_BITS: off_q  <= cfg_data;
					CFG_SET_BITS:    setb_q <= cfg_data[3:0];
					CFG_WAYS:        ways_q <= cfg_data;
					default:         off_q  <= off_q;
				endcase
			end
			case (cmd.op)
				CMD_CLEAR: row_q <= (st.row_last) ? '0 : row_q + ROW_W'(1);
				CMD_SWEEP_START: begin
					row_q   <= '0;
					sw_ok_q <= 1'b0;
				end
				CMD_SWEEP: begin
					row_q   <= (st.row_last) ? '0 : row_q + ROW_W'(1);
					sw_ok_q <= 1'b1;
				end
				CMD_SWEEP_END: begin
					sw_ok_q    <= 1'b0;
					cnt_q      <= '0;
					era_sb_q   <= eff_sb;
					era_ways_q <= eff_ways;
				end
				CMD_INDEX: cnt_q <= cnt_q + STAMP_W'(1);
				default:   row_q <= row_q;
			endcase
			if (cmd.op == CMD_UPDATE)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign st.row_last = (row_q == ROW_W'(MAX_SETS - 1));
	assign st.out_busy = out_valid_q && out_stall;
	assign out_valid   = out_valid_q;
	assign hit         = hit_q;

endmodule

// ===== test/testbench.sv =====
// testbench for the set associative cache lookup block with lru replacement
// drives address items, predicts hit or miss, checks every result in order
// depends on sacl_pkg and set_assoc_cache_lru_lookup
`timescale 1ns / 1ps

module testbench;
	import sacl_pkg::*;

	localparam int NUM_SETS   = 1024;
	localparam int NUM_WAYS   = 16;
	localparam int NUM_LINES  = NUM_SETS * NUM_WAYS;
	localparam int TOP_SB     = 10;
	localparam int WDOG_LIMIT = 40000;
	localparam int CFG_PAUSE  = NUM_SETS + 64;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	set_assoc_cache_lru_lookup u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .address(address),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor copy of the tag store and geometry
	logic        tag_vld [NUM_LINES];
	logic [31:0] tag_val [NUM_LINES];
	logic [31:0] tag_age [NUM_LINES];
	logic [4:0]  geo_ob = 5'd4;
	logic [3:0]  geo_sb = 4'd0;
	logic [4:0]  geo_ways = 5'd1;

	logic [31:0] addr_pending[$];
	bit          hit_expected[$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          hits_seen = 0;
	int          idle_mode = 0;
	int          wdog = 0;

	// lookup with global ageing, lru fill on miss
	function automatic bit predict_hit(logic [31:0] a);
		int sb, ways, sets, s, w, base, victim, i;
		logic [63:0] tag;
		logic [31:0] oldest;
		bit found;
		sb = (geo_sb > TOP_SB) ? TOP_SB : geo_sb;
		ways = (geo_ways == 0) ? 1 : ((geo_ways > NUM_WAYS) ? NUM_WAYS : geo_ways);
		sets = 1 << sb;
		for (s = 0; s < sets; s++)
			for (w = 0; w < ways; w++) begin
				i = s * NUM_WAYS + w;
				if (tag_vld[i] && tag_age[i] != AGE_TOP) tag_age[i]++;
			end
		s = int'((64'(a) >> geo_ob) & 64'(sets - 1));
		tag = 64'(a) >> (geo_ob + sb);
		base = s * NUM_WAYS;
		for (w = 0; w < ways; w++)
			if (tag_vld[base + w] && tag_val[base + w] == tag[31:0]) begin
				tag_age[base + w] = '0;
				return 1'b1;
			end
		found = 1'b0;
		victim = 0;
		for (w = 0; w < ways; w++)
			if (!found && !tag_vld[base + w]) begin
				victim = w;
				found = 1'b1;
			end
		if (!found) begin
			oldest = tag_age[base];
			for (w = 1; w < ways; w++)
				if (tag_age[base + w] > oldest) begin
					oldest = tag_age[base + w];
					victim = w;
				end
		end
		tag_vld[base + victim] = 1'b1;
		tag_val[base + victim] = tag[31:0];
		tag_age[base + victim] = '0;
		return 1'b0;
	endfunction

	// driver: takes items from the pending queue
	always @(posedge clk) begin
		bit taken, idle;
		logic [31:0] nxt;
		taken = in_valid && !in_stall;
		if (taken) begin
			hit_expected.push_back(predict_hit(address));
			items_sent++;
		end
		idle = (idle_mode == 1 && $urandom_range(99) < 75) ||
			(idle_mode == 3 && $urandom_range(99) < 24);
		if (!in_valid || taken) begin
			if (addr_pending.size() > 0 && !idle) begin
				nxt = addr_pending.pop_front();
				address <= nxt;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compares each result with the oldest expectation
	always @(posedge clk) begin
		bit exp_hit;
		if (out_valid && !out_stall) begin
			if (hit_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: hit=%0b", hit);
			end else begin
				exp_hit = hit_expected.pop_front();
				if (hit) hits_seen++;
				if (hit !== exp_hit) begin
					mismatches++;
					if (mismatches <= 10)
						$display("hit mismatch: expected %0b actual %0b", exp_hit, hit);
				end
			end
		end
		out_stall <= (idle_mode == 2 && $urandom_range(99) < 75) ||
			(idle_mode == 3 && $urandom_range(99) < 24);
	end

	// watchdog on cycles with work outstanding but no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(addr_pending.size() == 0 && hit_expected.size() == 0 && !in_valid))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic wait_drained();
		while (addr_pending.size() > 0 || in_valid || hit_expected.size() > 0)
			@(posedge clk);
	endtask

	// register write while idle, with a pause for any pass still running
	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		repeat (CFG_PAUSE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_OFFSET_BITS: geo_ob = val;
			CFG_SET_BITS:    geo_sb = val[3:0];
			CFG_WAYS:        geo_ways = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random addresses drawn mostly from a small pool so lines are reused
	task automatic queue_random(int n, int pool_n);
		logic [31:0] pool[64];
		logic [31:0] lowmask;
		int k;
		lowmask = (geo_ob >= 32) ? 32'hffff_ffff : ((32'd1 << geo_ob) - 1);
		for (k = 0; k < pool_n; k++) pool[k] = $urandom;
		for (k = 0; k < n; k++)
			if ($urandom_range(99) < 15)
				addr_pending.push_back($urandom);
			else
				addr_pending.push_back((pool[$urandom_range(pool_n - 1)] & ~lowmask) |
					($urandom & lowmask));
	endtask

	task automatic run_phase(int ob, int sb, int ways, int n, int pool_n, int mode);
		write_reg(CFG_OFFSET_BITS, 5'(ob));
		write_reg(CFG_SET_BITS, 5'(sb));
		write_reg(CFG_WAYS, 5'(ways));
		idle_mode = mode;
		queue_random(n, pool_n);
		wait_drained();
	endtask

	initial begin
		int i;
		for (i = 0; i < NUM_LINES; i++) begin
			tag_vld[i] = 1'b0;
			tag_val[i] = '0;
			tag_age[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset geometry, one way, eviction and hits, field extremes
		addr_pending.push_back(32'h0000_0000);
		addr_pending.push_back(32'h0000_000f);
		addr_pending.push_back(32'hffff_ffff);
		addr_pending.push_back(32'hffff_fff0);
		addr_pending.push_back(32'h0000_0010);
		addr_pending.push_back(32'h0000_0000);
		addr_pending.push_back(32'h8000_0000);
		addr_pending.push_back(32'h8000_0008);
		wait_drained();
		// four ways in one set: fill, hit, then lru eviction with ties
		write_reg(CFG_WAYS, 5'd4);
		for (i = 0; i < 5; i++) addr_pending.push_back(32'(i) << 4);
		addr_pending.push_back(32'h10);
		addr_pending.push_back(32'h20);
		addr_pending.push_back(32'h0);
		addr_pending.push_back(32'h50);
		addr_pending.push_back(32'h10);
		wait_drained();
		// unknown register index must leave the geometry alone
		write_reg(CFG_UNUSED, 5'd31);
		addr_pending.push_back(32'h20);
		addr_pending.push_back(32'h50);
		wait_drained();

		run_phase(4, 2, 4, 300, 20, 0);
		// sender holds off mid phase until all results are back
		write_reg(CFG_OFFSET_BITS, 5'd0);
		write_reg(CFG_SET_BITS, 5'd0);
		write_reg(CFG_WAYS, 5'd16);
		idle_mode = 1;
		queue_random(120, 24);
		wait_drained();
		queue_random(130, 24);
		wait_drained();
		run_phase(6, 3, 2, 250, 24, 2);
		run_phase(16, 10, 16, 40, 40, 3);
		run_phase(31, 15, 0, 60, 4, 0);
		run_phase(2, 1, 31, 250, 40, 3);
		run_phase(5, 4, 8, 300, 64, 1);

		wait_drained();
		repeat (40) @(posedge clk);
		$display("covered %0d lookups over nine geometries, %0d hits, idle and stall mixes",
			items_sent, hits_seen);
		if (mismatches == 0 && hit_expected.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
